/* design/mkd_pkg.sv */
// Shared types and constants for the multi-key debounce block.
package mkd_pkg;

    localparam int NUM_KEYS   = 7;
    localparam int DBC_W      = 8;
    localparam int LONG_W     = 16;
    localparam int HOLD_W     = LONG_W + 1;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [NUM_KEYS-1:0] KEY_ALL = {NUM_KEYS{1'b1}};

    localparam logic [DBC_W-1:0]  DEBOUNCE_RESET = 8'd2;
    localparam logic [LONG_W-1:0] LONG_RESET     = 16'd100;

    // Register byte addresses
    localparam logic [PADDR_W-1:0] ADDR_DEBOUNCE = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_LONG     = 3'd4;

    typedef struct packed {
        logic [DBC_W-1:0]  debounce_ticks;
        logic [LONG_W-1:0] long_press_ticks;
    } cfg_t;

    typedef struct packed {
        logic [NUM_KEYS-1:0] short_flags;
        logic [NUM_KEYS-1:0] long_flags;
        logic [NUM_KEYS-1:0] released_pins;
    } result_t;

endpackage

/* design/mkd_if.sv */
// Valid/ready channel interfaces for key samples and flag results.
interface mkd_in_if;
    logic                         valid;
    logic                         ready;
    logic [mkd_pkg::NUM_KEYS-1:0] pin_sample;
    logic [mkd_pkg::NUM_KEYS-1:0] short_clear_mask;

    modport source (output valid, output pin_sample, output short_clear_mask, input ready);
    modport sink   (input valid, input pin_sample, input short_clear_mask, output ready);
endinterface

interface mkd_out_if;
    logic                         valid;
    logic                         ready;
    logic [mkd_pkg::NUM_KEYS-1:0] short_flags;
    logic [mkd_pkg::NUM_KEYS-1:0] long_flags;
    logic [mkd_pkg::NUM_KEYS-1:0] released_pins;

    modport source (output valid, output short_flags, output long_flags,
                    output released_pins, input ready);
    modport sink   (input valid, input short_flags, input long_flags,
                    input released_pins, output ready);
endinterface

/* design/multi_key_debounce_short_long_press.sv */
// Multi-key debounce with short- and long-press flags.
//
// item_in carries one tick: an active-low sample of the key pins and a mask
// of short flags to clear after they are reported. item_out carries one
// result for every accepted item: the short flags before clearing, the long
// flags and the sample echoed back, in input order.
// The item lands in the input register, and the scan update loads the result
// register from it when that register has room. The update is a few compares,
// a 17-bit hold counter and an 8-bit debounce counter, so an item is taken
// every cycle while the receiver keeps taking results.
// When the receiver stalls, the result register holds and the input register
// keeps its item, or takes one more if it was empty; after that item_in.ready
// drops until the result is taken. No item is lost or repeated.
// Reset clears all flags and counters, sets the captured pattern to all
// released, and loads debounce_ticks = 2 and long_press_ticks = 100.
// Registers (APB): 0x0 debounce_ticks [7:0], 0x4 long_press_ticks [15:0];
// write them only while the block is idle.
module multi_key_debounce_short_long_press
(
    input  logic                         clk,
    input  logic                         rst_n,
    mkd_in_if.sink                       item_in,
    mkd_out_if.source                    item_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mkd_pkg::PADDR_W-1:0]  paddr,
    input  logic [mkd_pkg::PDATA_W-1:0]  pwdata,
    output logic [mkd_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    mkd_pkg::cfg_t    cfg;
    mkd_pkg::result_t result;

    logic                         s1_valid_reg;
    logic [mkd_pkg::NUM_KEYS-1:0] s1_pins_reg;
    logic [mkd_pkg::NUM_KEYS-1:0] s1_clr_reg;
    logic                         out_valid_reg;
    mkd_pkg::result_t             out_reg;
    logic                         advance;

    // move stage one into the result register when there is room
    assign advance       = s1_valid_reg && (!out_valid_reg || item_out.ready);
    assign item_in.ready = !s1_valid_reg || advance;

    mkd_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mkd_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .pins   (s1_pins_reg),
        .clr    (s1_clr_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_in.ready)
                s1_valid_reg <= item_in.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (item_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_in.ready && item_in.valid)
        begin
            s1_pins_reg <= item_in.pin_sample;
            s1_clr_reg  <= item_in.short_clear_mask;
        end
        if (advance)
            out_reg <= result;
    end

    assign item_out.valid         = out_valid_reg;
    assign item_out.short_flags   = out_reg.short_flags;
    assign item_out.long_flags    = out_reg.long_flags;
    assign item_out.released_pins = out_reg.released_pins;

endmodule

/* design/mkd_cfg.sv */
// APB configuration registers for debounce and long-press thresholds.
module mkd_cfg
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mkd_pkg::PADDR_W-1:0]  paddr,
    input  logic [mkd_pkg::PDATA_W-1:0]  pwdata,
    output logic [mkd_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output mkd_pkg::cfg_t                cfg
);

    logic [mkd_pkg::DBC_W-1:0]  debounce_reg;
    logic [mkd_pkg::LONG_W-1:0] long_reg;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= mkd_pkg::DEBOUNCE_RESET;
            long_reg     <= mkd_pkg::LONG_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr)
                mkd_pkg::ADDR_DEBOUNCE: debounce_reg <= pwdata[mkd_pkg::DBC_W-1:0];
                mkd_pkg::ADDR_LONG:     long_reg     <= pwdata[mkd_pkg::LONG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            mkd_pkg::ADDR_DEBOUNCE:
                prdata = {{(mkd_pkg::PDATA_W-mkd_pkg::DBC_W){1'b0}}, debounce_reg};
            mkd_pkg::ADDR_LONG:
                prdata = {{(mkd_pkg::PDATA_W-mkd_pkg::LONG_W){1'b0}}, long_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.debounce_ticks   = debounce_reg;
    assign cfg.long_press_ticks = long_reg;

endmodule

/* design/mkd_core.sv */
// Key scan state and per-tick update: capture, confirm, hold timing, flags.
module mkd_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [mkd_pkg::NUM_KEYS-1:0] pins,
    input  logic [mkd_pkg::NUM_KEYS-1:0] clr,
    input  mkd_pkg::cfg_t                cfg,
    output mkd_pkg::result_t             result
);

    logic [mkd_pkg::NUM_KEYS-1:0] short_reg, short_next;
    logic [mkd_pkg::NUM_KEYS-1:0] long_reg, long_next;
    logic [mkd_pkg::NUM_KEYS-1:0] captured_reg, captured_next;
    logic [mkd_pkg::NUM_KEYS-1:0] held_reg, held_next;
    logic [mkd_pkg::HOLD_W-1:0]   hold_reg, hold_next;
    logic [mkd_pkg::DBC_W-1:0]    dbc_reg, dbc_next;

    logic [mkd_pkg::NUM_KEYS-1:0] held_conf;
    logic [mkd_pkg::NUM_KEYS-1:0] short_rep;
    logic [mkd_pkg::HOLD_W-1:0]   long_lim;

    assign long_lim = {1'b0, cfg.long_press_ticks};

    always_comb
    begin
        captured_next = captured_reg;
        held_conf     = held_reg;
        dbc_next      = dbc_reg;
        short_rep     = short_reg;
        long_next     = long_reg;
        hold_next     = hold_reg;

        // confirm the captured pattern if it still matches the pins once the debounce count has run out
        if (dbc_reg == '0 && captured_reg != mkd_pkg::KEY_ALL)
        begin
            if (captured_reg == pins)
                held_conf = ~captured_reg;
            captured_next = mkd_pkg::KEY_ALL;
        end

        // capture a fresh pattern when idle
        if (pins != mkd_pkg::KEY_ALL && dbc_reg == '0 && held_conf == '0)
        begin
            captured_next = pins;
            dbc_next      = cfg.debounce_ticks;
        end

        held_next = held_conf;
        if (held_conf != '0)
        begin
            if (hold_reg < long_lim)
            begin
                hold_next = hold_reg + 1'b1;
                short_rep = short_reg | (held_conf & pins);
            end
            else if (hold_reg == long_lim)
            begin
                hold_next = hold_reg + 1'b1;
                long_next = held_conf;
            end
            held_next = held_conf & ~pins;
        end
        else
        begin
            long_next = '0;
            hold_next = '0;
        end

        if (dbc_next != '0)
            dbc_next = dbc_next - 1'b1;

        short_next = short_rep & ~clr;
    end

    assign result.short_flags   = short_rep;
    assign result.long_flags    = long_next;
    assign result.released_pins = pins;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_reg    <= '0;
            long_reg     <= '0;
            captured_reg <= mkd_pkg::KEY_ALL;
            held_reg     <= '0;
            hold_reg     <= '0;
            dbc_reg      <= '0;
        end
        else if (step)
        begin
            short_reg    <= short_next;
            long_reg     <= long_next;
            captured_reg <= captured_next;
            held_reg     <= held_next;
            hold_reg     <= hold_next;
            dbc_reg      <= dbc_next;
        end
    end

endmodule
